FILE: src/clfd_pkg.sv
package clfd_pkg;

  localparam int unsigned COUNT_BITS_DEF = 24;

  localparam logic [23:0] MAX_PAYLOAD_RST = 24'd8388608;
  localparam logic [0:0]  REG_MAX_PAYLOAD = 1'b0;

  localparam logic [4:0] PREFIX_LEN = 5'd16;
  localparam logic [1:0] SEP_LEN    = 2'd2;

  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_MISSING_SEP = 3'd1,
    ERR_BAD_HEADER  = 3'd2,
    ERR_BAD_LENGTH  = 3'd3,
    ERR_TOO_LARGE   = 3'd4,
    ERR_TRUNCATED   = 3'd5
  } err_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       eof;
    err_e       code;
  } result_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2d;
      4'd8:    c = 8'h4c;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6e;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3a;
      4'd15:   c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: src/clfd_out_buf.sv
module clfd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  clfd_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output clfd_pkg::result_t out_data_o
);
  import clfd_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    pop;

  assign pop = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_data_d  = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: src/content_length_frame_deframer.sv
// the result of an accepted item is registered in the result buffer before it is offered
// one item per cycle unless the buffer is full; single parse step between state and result
// a two-entry result buffer keeps input transfers going while one result waits
// reset: asynchronous, active low; parser returns to the header line, max_payload to 8388608
// after an error or clean end the block takes items without results until reset
module content_length_frame_deframer #(
  parameter int unsigned COUNT_BITS = clfd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_input_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic        end_of_frame_o,
  output logic [2:0]  error_code_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import clfd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_SEP     = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_HALT    = 2'd3
  } phase_e;

  localparam logic [32:0] CAP = (33'd1 << COUNT_BITS) - 33'd1;

  phase_e                  phase_q, phase_d;
  logic [4:0]              column_q, column_d;
  logic                    pm_q, pm_d;
  logic                    crp_q, crp_d;
  logic                    digit_q, digit_d;
  logic                    mal_q, mal_d;
  logic [63:0]             len_q, len_d;
  logic                    wrap_q, wrap_d;
  logic [COUNT_BITS-1:0]   rem_q, rem_d;
  logic [23:0]             max_payload_q;

  logic                    accept;
  logic                    has_res;
  result_t                 res;
  logic                    buf_full;
  result_t                 out_res;
  err_e                    hdr_code;
  logic [32:0]             limit;
  logic                    too_large;
  logic [4:0]              col_a;
  logic                    pm_a;
  logic                    mal_a;
  logic                    b_in_prefix;
  logic                    b_digit;
  logic [67:0]             len_ext;
  logic [67:0]             len_next;

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {8'd0, max_payload_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_PAYLOAD) begin
      max_payload_q <= pwdata[23:0];
    end
  end

  // header line checks
  assign limit     = (CAP < {9'd0, max_payload_q}) ? CAP : {9'd0, max_payload_q};
  assign too_large = (|len_q[63:33]) || (len_q[32:0] > limit);

  always_comb begin
    if (!crp_q) begin
      hdr_code = ERR_MISSING_SEP;
    end else if (column_q < PREFIX_LEN || !pm_q) begin
      hdr_code = ERR_BAD_HEADER;
    end else if (!digit_q || mal_q || wrap_q) begin
      hdr_code = ERR_BAD_LENGTH;
    end else if (too_large) begin
      hdr_code = ERR_TOO_LARGE;
    end else begin
      hdr_code = ERR_NONE;
    end
  end

  // deferred cr taken as content first, then the new byte
  assign col_a = (crp_q && column_q < PREFIX_LEN) ? column_q + 5'd1 : column_q;
  assign pm_a  = pm_q && !(crp_q && column_q < PREFIX_LEN &&
                           prefix_char(column_q[3:0]) != CHAR_CR);
  assign mal_a = mal_q || (crp_q && column_q >= PREFIX_LEN);

  assign b_in_prefix = col_a < PREFIX_LEN;
  assign b_digit     = data_byte_i >= CHAR_ZERO && data_byte_i <= CHAR_NINE;

  // times ten plus digit, carry-out above 64 bits flags a wrap
  assign len_ext  = {4'd0, len_q};
  assign len_next = (len_ext << 3) + (len_ext << 1) +
                    {64'd0, 4'(data_byte_i - CHAR_ZERO)};

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    phase_d  = phase_q;
    column_d = column_q;
    pm_d     = pm_q;
    crp_d    = crp_q;
    digit_d  = digit_q;
    mal_d    = mal_q;
    len_d    = len_q;
    wrap_d   = wrap_q;
    rem_d    = rem_q;
    has_res  = 1'b0;
    res      = '{kind: KIND_BYTE, data: 8'd0, eof: 1'b0, code: ERR_NONE};
    case (phase_q)
      PH_HEADER: begin
        if (end_of_input_i) begin
          has_res = 1'b1;
          phase_d = PH_HALT;
          if (column_q == 5'd0 && !crp_q) begin
            res.kind = KIND_END;
          end else begin
            res.kind = KIND_ERROR;
            res.code = (hdr_code != ERR_NONE) ? hdr_code : ERR_MISSING_SEP;
          end
        end else if (data_byte_i == CHAR_LF) begin
          if (hdr_code != ERR_NONE) begin
            has_res  = 1'b1;
            phase_d  = PH_HALT;
            res.kind = KIND_ERROR;
            res.code = hdr_code;
          end else begin
            phase_d  = PH_SEP;
            column_d = 5'd0;
            pm_d     = 1'b1;
            crp_d    = 1'b0;
            digit_d  = 1'b0;
            mal_d    = 1'b0;
            wrap_d   = 1'b0;
          end
        end else if (data_byte_i == CHAR_CR) begin
          crp_d    = 1'b1;
          column_d = col_a;
          pm_d     = pm_a;
          mal_d    = mal_a;
        end else begin
          crp_d = 1'b0;
          mal_d = mal_a;
          if (b_in_prefix) begin
            pm_d     = pm_a && (data_byte_i == prefix_char(col_a[3:0]));
            column_d = col_a + 5'd1;
          end else begin
            pm_d     = pm_a;
            column_d = col_a;
            if (b_digit) begin
              digit_d = 1'b1;
              wrap_d  = wrap_q || (|len_next[67:64]);
              len_d   = len_next[63:0];
            end else begin
              mal_d = 1'b1;
            end
          end
        end
      end
      PH_SEP: begin
        if (end_of_input_i || data_byte_i == CHAR_LF) begin
          has_res = 1'b1;
          if (!(column_q == 5'd1 && crp_q)) begin
            phase_d  = PH_HALT;
            res.kind = KIND_ERROR;
            res.code = ERR_MISSING_SEP;
          end else if (len_q == 64'd0) begin
            phase_d  = PH_HEADER;
            column_d = 5'd0;
            pm_d     = 1'b1;
            crp_d    = 1'b0;
            digit_d  = 1'b0;
            mal_d    = 1'b0;
            wrap_d   = 1'b0;
            len_d    = 64'd0;
            rem_d    = '0;
            res.kind = KIND_EMPTY;
            res.eof  = 1'b1;
          end else if (end_of_input_i) begin
            phase_d  = PH_HALT;
            res.kind = KIND_ERROR;
            res.code = ERR_TRUNCATED;
          end else begin
            has_res  = 1'b0;
            phase_d  = PH_PAYLOAD;
            rem_d    = len_q[COUNT_BITS-1:0];
            column_d = 5'd0;
            pm_d     = 1'b1;
            crp_d    = 1'b0;
            digit_d  = 1'b0;
            mal_d    = 1'b0;
            wrap_d   = 1'b0;
          end
        end else begin
          if (column_q == 5'd0 && data_byte_i == CHAR_CR) begin
            crp_d = 1'b1;
          end
          if (column_q < {3'd0, SEP_LEN}) begin
            column_d = column_q + 5'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        has_res = 1'b1;
        if (end_of_input_i) begin
          phase_d  = PH_HALT;
          res.kind = KIND_ERROR;
          res.code = ERR_TRUNCATED;
        end else begin
          res.kind = KIND_BYTE;
          res.data = data_byte_i;
          if (rem_q <= COUNT_BITS'(1)) begin
            res.eof  = 1'b1;
            phase_d  = PH_HEADER;
            column_d = 5'd0;
            pm_d     = 1'b1;
            crp_d    = 1'b0;
            digit_d  = 1'b0;
            mal_d    = 1'b0;
            wrap_d   = 1'b0;
            len_d    = 64'd0;
            rem_d    = '0;
          end else begin
            rem_d = rem_q - COUNT_BITS'(1);
          end
        end
      end
      PH_HALT: begin
        has_res = 1'b0;
      end
      default: begin
        phase_d = PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      column_q <= 5'd0;
      pm_q     <= 1'b1;
      crp_q    <= 1'b0;
      digit_q  <= 1'b0;
      mal_q    <= 1'b0;
      len_q    <= 64'd0;
      wrap_q   <= 1'b0;
      rem_q    <= '0;
    end else if (accept) begin
      phase_q  <= phase_d;
      column_q <= column_d;
      pm_q     <= pm_d;
      crp_q    <= crp_d;
      digit_q  <= digit_d;
      mal_q    <= mal_d;
      len_q    <= len_d;
      wrap_q   <= wrap_d;
      rem_q    <= rem_d;
    end
  end

  clfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && has_res),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign in_ready_o     = !buf_full;
  assign result_kind_o  = out_res.kind;
  assign payload_byte_o = out_res.data;
  assign end_of_frame_o = out_res.eof;
  assign error_code_o   = out_res.code;

  // a held result is always on the output
  a_full_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("result buffer full without a visible result");

  // halt is left only through reset
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |=> phase_q == PH_HALT)
    else $error("left halt without reset");

  // payload phase always has bytes left
  a_payload_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != '0)
    else $error("payload phase with zero bytes remaining");

  // error results carry a code, other kinds do not
  a_error_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((result_kind_o == KIND_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code does not match result kind");

endmodule

FILE: verif/tb_content_length_frame_deframer.sv
module tb_content_length_frame_deframer;
  import clfd_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 150;
  localparam int CHUNK_ITEMS  = 50;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_PRINTS   = 100;
  localparam logic [63:0] COUNT_CAP = (64'd1 << COUNT_BITS_DEF) - 64'd1;
  localparam logic [2:0] ADDR_MAX_PAYLOAD = {REG_MAX_PAYLOAD, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;

  typedef enum logic [1:0] {
    LINE_HEADER,
    LINE_SEP,
    IN_PAYLOAD,
    HALTED
  } parse_phase_e;

  typedef enum int {
    END_CLEAN,
    END_NO_CR,
    END_BAD_PREFIX,
    END_SHORT_PREFIX,
    END_NO_DIGITS,
    END_BAD_DIGIT,
    END_HUGE_VALUE,
    END_OVER_LIMIT,
    END_CUT_PAYLOAD,
    END_CUT_SEPARATOR,
    END_BAD_SEPARATOR,
    END_CUT_HEADER,
    END_EMPTY_SEPARATOR
  } stream_end_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        end_of_input_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  result_kind_o;
  logic [7:0]  payload_byte_o;
  logic        end_of_frame_o;
  logic [2:0]  error_code_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  content_length_frame_deframer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_kind_o  (result_kind_o),
    .payload_byte_o (payload_byte_o),
    .end_of_frame_o (end_of_frame_o),
    .error_code_o   (error_code_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // parser shadow state
  parse_phase_e ph;
  logic [4:0]   col;
  logic         prefix_ok;
  logic         cr_pending;
  logic         have_digit;
  logic         bad_char;
  logic         len_overflow;
  logic [63:0]  len_value;
  logic [23:0]  left_bytes;
  logic [23:0]  max_len;

  string hdr_text = "Content-Length: ";

  result_t     frame_results_q[$];
  int          items_sent;
  int          frames_sent;
  int          results_seen;
  int          mismatches;
  bit          sender_burst;
  bit          hold_req;
  stream_end_e ending;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_line_state();
    col          = 5'd0;
    prefix_ok    = 1'b1;
    cr_pending   = 1'b0;
    have_digit   = 1'b0;
    bad_char     = 1'b0;
    len_overflow = 1'b0;
  endfunction

  function automatic void restart_header();
    clear_line_state();
    len_value  = 64'd0;
    left_bytes = 24'd0;
    ph         = LINE_HEADER;
  endfunction

  function automatic void take_header_char(input logic [7:0] c);
    logic [63:0] d;
    if (col < PREFIX_LEN) begin
      if (c != hdr_text[col]) prefix_ok = 1'b0;
      col = col + 5'd1;
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = {56'd0, c - CHAR_ZERO};
      have_digit = 1'b1;
      if (len_value > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) len_overflow = 1'b1;
      len_value = len_value * 64'd10 + d;
    end else begin
      bad_char = 1'b1;
    end
  endfunction

  function automatic err_e line_check();
    logic [63:0] limit;
    limit = {40'd0, max_len};
    if (COUNT_CAP < limit) limit = COUNT_CAP;
    if (!cr_pending) return ERR_MISSING_SEP;
    if (col < PREFIX_LEN || !prefix_ok) return ERR_BAD_HEADER;
    if (!have_digit || bad_char || len_overflow) return ERR_BAD_LENGTH;
    if (len_value > limit) return ERR_TOO_LARGE;
    return ERR_NONE;
  endfunction

  function automatic result_t pack_result(input kind_e k, input logic [7:0] b, input logic e,
                                          input err_e c);
    result_t r;
    r.kind = k;
    r.data = b;
    r.eof  = e;
    r.code = c;
    return r;
  endfunction

  function automatic bit predict_item(input logic [7:0] b, input logic eoi, output result_t r);
    err_e fail_code;
    bit   got;
    fail_code = ERR_NONE;
    got       = 1'b0;
    r         = pack_result(KIND_BYTE, 8'd0, 1'b0, ERR_NONE);
    case (ph)
      LINE_HEADER: begin
        if (eoi) begin
          if (col == 5'd0 && !cr_pending) begin
            r   = pack_result(KIND_END, 8'd0, 1'b0, ERR_NONE);
            ph  = HALTED;
            got = 1'b1;
          end else begin
            fail_code = line_check();
            if (fail_code == ERR_NONE) fail_code = ERR_MISSING_SEP;
          end
        end else if (b == CHAR_LF) begin
          fail_code = line_check();
          if (fail_code == ERR_NONE) begin
            clear_line_state();
            ph = LINE_SEP;
          end
        end else begin
          if (cr_pending) take_header_char(CHAR_CR);
          if (b == CHAR_CR) begin
            cr_pending = 1'b1;
          end else begin
            cr_pending = 1'b0;
            take_header_char(b);
          end
        end
      end
      LINE_SEP: begin
        if (eoi || b == CHAR_LF) begin
          if (!(col == 5'd1 && cr_pending)) begin
            fail_code = ERR_MISSING_SEP;
          end else if (len_value == 64'd0) begin
            restart_header();
            r   = pack_result(KIND_EMPTY, 8'd0, 1'b1, ERR_NONE);
            got = 1'b1;
          end else if (eoi) begin
            fail_code = ERR_TRUNCATED;
          end else begin
            left_bytes = len_value[23:0];
            clear_line_state();
            ph = IN_PAYLOAD;
          end
        end else begin
          if (col == 5'd0 && b == CHAR_CR) cr_pending = 1'b1;
          if (col < SEP_LEN) col = col + 5'd1;
        end
      end
      IN_PAYLOAD: begin
        if (eoi) begin
          fail_code = ERR_TRUNCATED;
        end else if (left_bytes <= 24'd1) begin
          restart_header();
          r   = pack_result(KIND_BYTE, b, 1'b1, ERR_NONE);
          got = 1'b1;
        end else begin
          left_bytes = left_bytes - 24'd1;
          r   = pack_result(KIND_BYTE, b, 1'b0, ERR_NONE);
          got = 1'b1;
        end
      end
      default: ;
    endcase
    if (fail_code != ERR_NONE) begin
      ph  = HALTED;
      r   = pack_result(KIND_ERROR, 8'd0, 1'b0, fail_code);
      got = 1'b1;
    end
    return got;
  endfunction

  // mostly short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    if (r[31:29] != 3'd0) return r[7:0];
    case (r[9:8])
      2'd0:    return CHAR_CR;
      2'd1:    return CHAR_LF;
      2'd2:    return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
    mismatches++;
  endtask

  task automatic check_result();
    result_t want;
    results_seen++;
    if (frame_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind %0d byte %02h eof %0d code %0d",
                                result_kind_o, payload_byte_o, end_of_frame_o, error_code_o));
    end else begin
      want = frame_results_q.pop_front();
      if (result_kind_o !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", result_kind_o, want.kind));
      if (payload_byte_o !== want.data)
        report_mismatch($sformatf("payload_byte %02h, expected %02h", payload_byte_o, want.data));
      if (end_of_frame_o !== want.eof)
        report_mismatch($sformatf("end_of_frame %0d, expected %0d", end_of_frame_o, want.eof));
      if (error_code_o !== want.code)
        report_mismatch($sformatf("error_code %0d, expected %0d", error_code_o, want.code));
    end
  endtask

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int      gap;
    result_t r;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_byte_i    <= b;
    end_of_input_i <= eoi;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (predict_item(b, eoi, r)) frame_results_q.push_back(r);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_MAX_PAYLOAD) max_len = data[23:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_max_payload_reg();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_PAYLOAD;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[23:0] !== max_len)
      report_mismatch($sformatf("max_payload reads %0d, expected %0d", prdata[23:0], max_len));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_max_payload(input logic [23:0] value);
    logic [31:0] junk;
    junk = $urandom;
    drain();
    reg_write(ADDR_MAX_PAYLOAD, {junk[31:24], value});
    check_max_payload_reg();
  endtask

  task automatic send_prefix();
    for (int i = 0; i < 16; i++) send_item(hdr_text[i], 1'b0);
  endtask

  task automatic send_digits(input logic [63:0] value, input int zeros);
    logic [7:0]  digs[$];
    logic [63:0] v;
    logic [63:0] t;
    v = value;
    repeat (zeros) send_item(CHAR_ZERO, 1'b0);
    do begin
      t = v % 64'd10;
      digs.push_front(CHAR_ZERO + t[7:0]);
      v = v / 64'd10;
    end while (v != 64'd0);
    foreach (digs[i]) send_item(digs[i], 1'b0);
  endtask

  task automatic send_frame_header(input logic [63:0] len, input int zeros);
    send_prefix();
    send_digits(len, zeros);
    send_item(CHAR_CR, 1'b0);
    send_item(CHAR_LF, 1'b0);
    send_item(CHAR_CR, 1'b0);
    send_item(CHAR_LF, 1'b0);
  endtask

  task automatic send_frame(input int len);
    int zeros;
    zeros = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (len == 0 && $urandom_range(0, 3) == 0) begin
      // empty frame closed by end of input right after the separator cr
      send_prefix();
      send_digits(64'd0, zeros);
      send_item(CHAR_CR, 1'b0);
      send_item(CHAR_LF, 1'b0);
      send_item(CHAR_CR, 1'b0);
      send_item(rand_byte(), 1'b1);
    end else begin
      send_frame_header(64'(len), zeros);
      for (int i = 0; i < len; i++) send_item(rand_byte(), 1'b0);
    end
    frames_sent++;
  endtask

  task automatic test_directed();
    check_max_payload_reg();
    send_frame_header(64'd0, 0);
    send_frame_header(64'd2, 3);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_prefix();
    send_digits(64'd0, 0);
    send_item(CHAR_CR, 1'b0);
    send_item(CHAR_LF, 1'b0);
    send_item(CHAR_CR, 1'b0);
    send_item(8'hA5, 1'b1);
    // long run of leading zeros, line-end bytes inside the payload
    send_frame_header(64'd3, 18);
    send_item(CHAR_CR, 1'b0);
    send_item(CHAR_LF, 1'b0);
    send_item(rand_byte(), 1'b0);
    drain();
  endtask

  task automatic test_config_sweep();
    int          lim;
    logic [31:0] r;
    set_max_payload(24'd0);
    repeat (4) send_frame(0);
    set_max_payload(24'hFFFFFF);
    repeat (4) send_frame($urandom_range(1, 20));
    lim = $urandom_range(1, 20);
    set_max_payload(lim[23:0]);
    send_frame(lim);
    send_frame(0);
    drain();
    reg_write(ADDR_UNMAPPED, $urandom);
    check_max_payload_reg();
    send_frame(lim);
    r = $urandom;
    set_max_payload(r[23:0]);
    repeat (3) send_frame($urandom_range(0, 12));
    drain();
  endtask

  task automatic test_random_stream();
    int          first;
    int          chunk_start;
    int          top;
    int          len;
    logic [31:0] r;
    first       = items_sent;
    chunk_start = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (items_sent - chunk_start >= CHUNK_ITEMS) begin
        r = $urandom;
        case (r[31:30])
          2'd0:    set_max_payload(24'd0);
          2'd1:    set_max_payload(24'hFFFFFF);
          2'd2:    set_max_payload(24'd1 + {18'd0, r[5:0]});
          default: set_max_payload(r[23:0]);
        endcase
        chunk_start = items_sent;
      end
      sender_burst = ($urandom_range(0, 4) == 0);
      top = (max_len < 24'd32) ? int'(max_len) : 32;
      if ($urandom_range(0, 3) == 0) len = $urandom_range(0, top);
      else len = $urandom_range(0, (top < 8) ? top : 8);
      send_frame(len);
    end
    sender_burst = 1'b0;
    drain();
  endtask

  // the sink stalls while a long frame keeps coming, so the input stalls too
  task automatic test_backpressure();
    set_max_payload(24'hFFFFFF);
    sender_burst = 1'b1;
    hold_req     = 1'b1;
    send_frame_header(64'd48, 0);
    for (int i = 0; i < 48; i++) send_item(rand_byte(), 1'b0);
    frames_sent++;
    sender_burst = 1'b0;
    drain();
  endtask

  task automatic test_stream_end();
    int          top;
    int          len;
    int          cut;
    logic [7:0]  m;
    logic [31:0] r;
    ending = stream_end_e'($urandom_range(0, int'(END_EMPTY_SEPARATOR)));
    r = $urandom;
    if (r[0]) set_max_payload(24'hFFFFFF);
    else set_max_payload(24'd1 + {19'd0, r[8:4]});
    top = (max_len < 24'd16) ? int'(max_len) : 16;
    len = $urandom_range(1, top);
    case (ending)
      END_CLEAN: send_item(rand_byte(), 1'b1);
      END_NO_CR: begin
        send_prefix();
        send_digits(64'(len), 0);
        send_item(CHAR_LF, 1'b0);
      end
      END_BAD_PREFIX: begin
        cut = $urandom_range(0, 15);
        m = rand_byte();
        if (m == 8'h00) m = 8'h20;
        for (int i = 0; i < 16; i++) send_item((i == cut) ? (hdr_text[i] ^ m) : hdr_text[i], 1'b0);
        send_digits(64'(len), 0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
      end
      END_SHORT_PREFIX: begin
        cut = $urandom_range(0, 15);
        for (int i = 0; i < cut; i++) send_item(hdr_text[i], 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
      end
      END_NO_DIGITS: begin
        send_prefix();
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
      end
      END_BAD_DIGIT: begin
        send_prefix();
        send_digits(64'(len), 0);
        r = $urandom_range(0, 25);
        send_item(r[4] ? CHAR_CR : (8'h61 + r[7:0]), 1'b0);
        if (r[0]) send_digits(64'(len), 0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
      end
      END_HUGE_VALUE: begin
        // all ones fits but exceeds the limit, one more digit wraps
        send_prefix();
        send_digits(64'hFFFF_FFFF_FFFF_FFFF, 0);
        r = $urandom_range(0, 9);
        if ($urandom_range(0, 1) == 1) send_item(CHAR_ZERO + r[7:0], 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
      end
      END_OVER_LIMIT: send_frame_header({40'd0, max_len} + 64'd1 + $urandom_range(0, 1000), 0);
      END_CUT_PAYLOAD: begin
        send_frame_header(64'(len), 0);
        repeat ($urandom_range(0, len - 1)) send_item(rand_byte(), 1'b0);
        send_item(rand_byte(), 1'b1);
      end
      END_CUT_SEPARATOR: begin
        send_prefix();
        send_digits(64'(len), 0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(rand_byte(), 1'b1);
      end
      END_BAD_SEPARATOR: begin
        send_prefix();
        send_digits(64'(len), 0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
        if ($urandom_range(0, 1) == 1) begin
          send_item(CHAR_CR, 1'b0);
          send_item(CHAR_CR, 1'b0);
        end
        send_item(CHAR_LF, 1'b0);
      end
      END_CUT_HEADER: begin
        cut = $urandom_range(0, 15);
        for (int i = 0; i < cut; i++) send_item(hdr_text[i], 1'b0);
        if ($urandom_range(0, 1) == 1) send_item(CHAR_CR, 1'b0);
        send_item(rand_byte(), 1'b1);
      end
      default: begin
        send_prefix();
        send_digits(64'(len), 0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
        if ($urandom_range(0, 1) == 1) send_item(8'h78, 1'b0);
        send_item(rand_byte(), 1'b1);
      end
    endcase
    // halted: nothing more comes out
    repeat (12) send_item(rand_byte(), ($urandom_range(0, 3) == 0));
    drain();
  endtask

  initial begin : result_sink
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) check_result();
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        calm_left  = 0;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && calm_left == 0) begin
        if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(30, 150);
        else stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (calm_left > 0) calm_left--;
      end
    end
  end

  initial begin : stall_watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable && pready)) idle = 0;
      else idle++;
    end
    $display("no transfer for %0d cycles, %0d results still expected", IDLE_LIMIT,
             frame_results_q.size());
    $display("content_length_frame_deframer test failed");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    data_byte_i    <= 8'd0;
    end_of_input_i <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= 3'd0;
    pwdata         <= 32'd0;
    items_sent   = 0;
    frames_sent  = 0;
    results_seen = 0;
    mismatches   = 0;
    sender_burst = 1'b0;
    hold_req     = 1'b0;
    ending       = END_CLEAN;
    max_len      = MAX_PAYLOAD_RST;
    restart_header();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_random_stream();
    test_backpressure();
    test_stream_end();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d bytes in %0d frames sent, %0d results checked, %0d mismatches",
             items_sent, frames_sent, results_seen, mismatches);
    $display("stream closed by %s with max_payload %0d", ending.name(), max_len);
    if (mismatches == 0) begin
      $display("content_length_frame_deframer test passed");
    end else begin
      $display("content_length_frame_deframer test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/clfd_pkg.sv
src/clfd_out_buf.sv
src/content_length_frame_deframer.sv
verif/tb_content_length_frame_deframer.sv
